// ===== rtl/core/ile_pkg.sv =====
// ============================================================================
// ile_pkg
// Shared types and codes for the indexed list engine: request and response
// beats, the opcode and status codes, and the control word that walks the
// cell chain.
// ============================================================================
`default_nettype none

package ile_pkg;

    localparam int DATA_W = 32;

    // Request opcodes.
    localparam logic [2:0] OPC_APPEND   = 3'd0;
    localparam logic [2:0] OPC_INSERT   = 3'd1;
    localparam logic [2:0] OPC_REMOVE   = 3'd2;
    localparam logic [2:0] OPC_POP_LAST = 3'd3;
    localparam logic [2:0] OPC_POP_AT   = 3'd4;
    localparam logic [2:0] OPC_READ     = 3'd5;
    localparam logic [2:0] OPC_WRITE    = 3'd6;

    // Response status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Action that a cell takes when the wave reaches it.
    typedef enum logic [2:0] {
        W_NOP,
        W_INS,
        W_REM,
        W_RD,
        W_WR
    } t_wop;

    typedef struct packed {
        logic vld;
        t_wop op;
        logic past;     // the wave has already passed its target cell
    } t_wave;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [7:0]               position;
        logic signed [DATA_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
        logic [8:0]               list_length;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/core/indexed_list_engine_core.sv =====
// ============================================================================
// indexed_list_engine_core
// Ordered list of signed 32-bit words with append, insert, remove, pop,
// read and write requests, built as a chain of storage cells.
// ============================================================================
// Each entry lives in its own cell, and a request travels down the chain as
// a wave, one cell per clock, so that inserts and removes shift every later
// entry by one place as the wave passes. Status and the new length are
// decided when the request beat is accepted; the result beat is presented
// only after the wave has passed every cell, for every opcode, errors
// included. The next request is taken only once the finished wave has
// returned the state machine to idle and the hold register is empty.
// One request is in the chain at a time. The
// response side has two beats of buffering, so a new request is taken while
// a finished response still waits downstream. The entry store needs no
// clearing after reset.
`default_nettype none

module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [1:0]               r_stat;
    logic [1:0]               n_stat;
    logic [8:0]               r_len;
    t_wave                    r_launch;
    logic [IDX_W-1:0]         r_tgt;
    logic signed [DATA_W-1:0] r_carry;
    logic                     r_out_vld;
    t_out                     r_out;
    logic                     r_hold_vld;
    t_out                     r_hold;

    t_wop                     l_op;
    logic [IDX_W-1:0]         l_tgt;
    logic [CMP_W-1:0]         pos_c;
    logic [CMP_W-1:0]         cnt_c;
    logic                     full;
    logic                     empty;
    logic                     in_acc;
    logic                     out_take;
    logic                     done;
    t_out                     done_beat;

    t_wave                    w_wave   [0:CAPACITY];
    logic [IDX_W-1:0]         w_tgt    [0:CAPACITY];
    logic signed [DATA_W-1:0] w_carry  [0:CAPACITY];
    logic signed [DATA_W-1:0] w_result [0:CAPACITY];
    logic signed [DATA_W-1:0] w_value  [0:CAPACITY-1];

    assign o_in_stall = (r_state != S_IDLE) || r_hold_vld;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pos_c      = CMP_W'(i_in_data.position);
    assign cnt_c      = CMP_W'(r_count);
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);

    always_comb begin
        l_op    = W_NOP;
        l_tgt   = '0;
        n_stat  = ST_OK;
        n_count = r_count;
        case (i_in_data.opcode)
            OPC_APPEND: begin
                if (full) begin
                    n_stat = ST_FULL;
                end else begin
                    l_op    = W_INS;
                    l_tgt   = IDX_W'(r_count);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OPC_INSERT: begin
                if (full) begin
                    n_stat = ST_FULL;
                end else if (pos_c > cnt_c) begin
                    n_stat = ST_RANGE;
                end else begin
                    l_op    = W_INS;
                    l_tgt   = IDX_W'(pos_c);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OPC_REMOVE, OPC_POP_AT: begin
                if (empty) begin
                    n_stat = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    n_stat = ST_RANGE;
                end else begin
                    l_op    = W_REM;
                    l_tgt   = IDX_W'(pos_c);
                    n_count = r_count - CNT_W'(1);
                end
            end
            OPC_POP_LAST: begin
                if (empty) begin
                    n_stat = ST_EMPTY;
                end else begin
                    l_op    = W_REM;
                    l_tgt   = IDX_W'(r_count - CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                end
            end
            OPC_READ: begin
                if (pos_c >= cnt_c) begin
                    n_stat = ST_RANGE;
                end else begin
                    l_op  = W_RD;
                    l_tgt = IDX_W'(pos_c);
                end
            end
            OPC_WRITE: begin
                if (pos_c >= cnt_c) begin
                    n_stat = ST_RANGE;
                end else begin
                    l_op  = W_WR;
                    l_tgt = IDX_W'(pos_c);
                end
            end
            default: begin
            end
        endcase
    end

    assign done = w_wave[CAPACITY].vld;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_launch <= '0;
        end else begin
            r_state      <= n_state;
            r_launch.vld <= in_acc;
            r_launch.op  <= l_op;
            r_launch.past <= 1'b0;
            if (in_acc) begin
                r_count <= n_count;
            end
        end
    end

    // Status and length ride beside the wave; only one request is in flight.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stat        <= n_stat;
            r_tgt         <= l_tgt;
            r_carry       <= i_in_data.item_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_len <= 9'(n_count);
        end
    end

    assign w_wave[0]   = r_launch;
    assign w_tgt[0]    = r_tgt;
    assign w_carry[0]  = r_carry;
    assign w_result[0] = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [DATA_W-1:0] nbr;
        if (gi == CAPACITY - 1) begin : g_last
            assign nbr = w_value[gi];
        end else begin : g_mid
            assign nbr = w_value[gi + 1];
        end
        ile_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wave      (w_wave[gi]),
            .i_tgt       (w_tgt[gi]),
            .i_carry     (w_carry[gi]),
            .i_result    (w_result[gi]),
            .i_nbr_value (nbr),
            .o_wave      (w_wave[gi + 1]),
            .o_tgt       (w_tgt[gi + 1]),
            .o_carry     (w_carry[gi + 1]),
            .o_result    (w_result[gi + 1]),
            .o_value     (w_value[gi])
        );
    end

    assign done_beat.result_value = w_result[CAPACITY];
    assign done_beat.status       = r_stat;
    assign done_beat.list_length  = r_len;
    assign out_take               = r_out_vld && !i_out_stall;

    // Two-beat response buffer: a finished beat goes to the output register,
    // or to the hold register while the output is still stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            if (done) begin
                if (!r_out_vld || out_take) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_hold_vld <= 1'b1;
                end
            end else if (out_take) begin
                if (r_hold_vld) begin
                    r_hold_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            if (!r_out_vld || out_take) begin
                r_out <= done_beat;
            end else begin
                r_hold <= done_beat;
            end
        end else if (out_take && r_hold_vld) begin
            r_out <= r_hold;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/ile_cell.sv =====
// ============================================================================
// ile_cell
// One storage cell of the list chain. It holds one entry and acts on the
// request wave as the wave passes by, then hands the wave to its neighbor.
// ============================================================================
`default_nettype none

module ile_cell
    import ile_pkg::*;
#(
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_wave                    i_wave,
    input  wire logic [IDX_W-1:0]         i_tgt,
    input  wire logic signed [DATA_W-1:0] i_carry,
    input  wire logic signed [DATA_W-1:0] i_result,
    input  wire logic signed [DATA_W-1:0] i_nbr_value,
    output t_wave                         o_wave,
    output logic [IDX_W-1:0]              o_tgt,
    output logic signed [DATA_W-1:0]      o_carry,
    output logic signed [DATA_W-1:0]      o_result,
    output logic signed [DATA_W-1:0]      o_value
);

    t_wave                    r_wave;
    t_wave                    n_wave;
    logic [IDX_W-1:0]         r_tgt;
    logic signed [DATA_W-1:0] r_carry;
    logic signed [DATA_W-1:0] n_carry;
    logic signed [DATA_W-1:0] r_result;
    logic signed [DATA_W-1:0] n_result;
    logic signed [DATA_W-1:0] r_store;
    logic signed [DATA_W-1:0] n_store;
    logic                     hit;
    logic                     at_or_after;

    assign hit         = i_wave.vld && (i_tgt == IDX_W'(CELL_IDX));
    assign at_or_after = hit || (i_wave.vld && i_wave.past);

    always_comb begin
        n_wave      = i_wave;
        n_wave.past = i_wave.past | hit;
        n_store     = r_store;
        n_carry     = i_carry;
        n_result    = i_result;
        case (i_wave.op)
            W_INS: begin
                // Each cell from the target on takes the word from upstream
                // and passes its old word down.
                if (at_or_after) begin
                    n_store = i_carry;
                    n_carry = r_store;
                end
            end
            W_REM: begin
                // The downstream cell has not been touched yet, so its word
                // is still the old one.
                if (hit) begin
                    n_result = r_store;
                end
                if (at_or_after) begin
                    n_store = i_nbr_value;
                end
            end
            W_RD: begin
                if (hit) begin
                    n_result = r_store;
                end
            end
            W_WR: begin
                if (hit) begin
                    n_store = i_carry;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt    <= i_tgt;
        r_carry  <= n_carry;
        r_result <= n_result;
        r_store  <= n_store;
    end

    assign o_wave   = r_wave;
    assign o_tgt    = r_tgt;
    assign o_carry  = r_carry;
    assign o_result = r_result;
    assign o_value  = r_store;

endmodule

`default_nettype wire

// ===== rtl/core/ile_checker.sv =====
// ============================================================================
// ile_checker
// Port-level checks for the indexed list engine, bound to the top level.
// ============================================================================
`default_nettype none

module ile_checker
    import ile_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out_data
);

    // A response beat held back by the consumer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("response beat changed while stalled");

    // Only one request is worked on at a time.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while another is in the chain");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL)
            |-> (o_out_data.list_length == 9'(CAPACITY)))
        else $error("full status with a list that is not full");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_EMPTY)
            |-> (o_out_data.list_length == 9'd0))
        else $error("empty status with a list that is not empty");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_value != '0)
            |-> (o_out_data.status == ST_OK))
        else $error("nonzero result word on an error response");

endmodule

bind indexed_list_engine_core ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for indexed_list_engine_core. It drives list requests
// with random idling on both channels, predicts every response from its own
// model of the list, and compares each response beat field by field.
// ============================================================================
`default_nettype none

module testbench;
    import ile_pkg::*;

    localparam int          LIST_CAPACITY = 256;
    localparam int          CYCLE_LIMIT   = 3000000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [2:0]  OPC_UNUSED    = 3'd7;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    // Predicted contents of the list and the responses still on their way.
    logic signed [DATA_W-1:0] list_words [LIST_CAPACITY];
    int unsigned              list_count = 0;
    t_out                     pending_rsp [$];

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          idle_on        = 1'b1;
    int          stall_left     = 0;

    logic [2:0] opc_order [8] = '{OPC_APPEND, OPC_INSERT, OPC_REMOVE, OPC_POP_LAST,
                                  OPC_POP_AT, OPC_READ, OPC_WRITE, OPC_UNUSED};

    indexed_list_engine_core #(
        .CAPACITY (LIST_CAPACITY)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stalls come in short bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin : check_responses
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                note_mismatch($sformatf({"response beat with none expected: ",
                                         "value %0d status %0d length %0d"},
                                        o_out_data.result_value, o_out_data.status,
                                        o_out_data.list_length));
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.result_value !== want.result_value ||
                    o_out_data.status !== want.status ||
                    o_out_data.list_length !== want.list_length) begin
                    note_mismatch($sformatf({"expected value %0d status %0d length %0d, ",
                                             "got value %0d status %0d length %0d"},
                                            want.result_value, want.status, want.list_length,
                                            o_out_data.result_value, o_out_data.status,
                                            o_out_data.list_length));
                end
            end
        end
    end

    // Removes the entry at idx and closes the gap behind it.
    function automatic logic signed [DATA_W-1:0] take_entry(input int unsigned idx);
        logic signed [DATA_W-1:0] word;
        int unsigned              k;
        word = list_words[idx];
        for (k = idx; k + 1 < list_count; k++)
            list_words[k] = list_words[k + 1];
        list_count--;
        return word;
    endfunction

    function automatic t_out apply_request(input t_in req);
        t_out        rsp;
        int unsigned pos;
        int unsigned k;
        rsp = '0;
        pos = 32'(req.position);
        case (req.opcode)
            OPC_APPEND: begin
                if (list_count >= LIST_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_words[list_count] = req.item_value;
                    list_count++;
                end
            end
            OPC_INSERT: begin
                if (list_count >= LIST_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else if (pos > list_count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    for (k = list_count; k > pos; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[pos] = req.item_value;
                    list_count++;
                end
            end
            OPC_REMOVE, OPC_POP_AT: begin
                if (list_count == 0)
                    rsp.status = ST_EMPTY;
                else if (pos >= list_count)
                    rsp.status = ST_RANGE;
                else
                    rsp.result_value = take_entry(pos);
            end
            OPC_POP_LAST: begin
                if (list_count == 0)
                    rsp.status = ST_EMPTY;
                else
                    rsp.result_value = take_entry(list_count - 1);
            end
            OPC_READ: begin
                if (pos >= list_count)
                    rsp.status = ST_RANGE;
                else
                    rsp.result_value = list_words[pos];
            end
            OPC_WRITE: begin
                if (pos >= list_count)
                    rsp.status = ST_RANGE;
                else
                    list_words[pos] = req.item_value;
            end
            default: begin
            end
        endcase
        rsp.list_length = 9'(list_count);
        return rsp;
    endfunction

    // Presents one request beat and returns at the edge that accepts it.
    // Valid stays high so that back-to-back beats need no second assignment.
    task automatic issue_request(input t_in req);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_rsp.push_back(apply_request(req));
    endtask

    task automatic issue_op(input logic [2:0] opc, input int unsigned pos,
                            input logic [DATA_W-1:0] word);
        t_in req;
        req.opcode     = opc;
        req.position   = 8'(pos);
        req.item_value = word;
        issue_request(req);
    endtask

    function automatic logic [2:0] pick_opcode(input t_mix mix);
        int unsigned w [8];
        int unsigned total;
        int unsigned r;
        int          k;
        case (mix)
            MIX_GROW:   w = '{40, 35, 4, 4, 4, 6, 5, 2};
            MIX_SHRINK: w = '{4, 4, 30, 25, 25, 5, 5, 2};
            default:    w = '{15, 15, 14, 14, 14, 13, 13, 2};
        endcase
        total = 0;
        for (k = 0; k < 8; k++)
            total += w[k];
        r = $urandom_range(0, total - 1);
        for (k = 0; k < 7; k++) begin
            if (r < w[k])
                return opc_order[k];
            r -= w[k];
        end
        return opc_order[7];
    endfunction

    // Positions lean toward the live part of the list, with its edges and
    // the far end of the index range mixed in.
    function automatic t_in make_request(input t_mix mix);
        t_in         req;
        int unsigned r;
        int unsigned top;
        top = (list_count > 255) ? 255 : list_count;
        req.opcode = pick_opcode(mix);
        r = $urandom_range(0, 19);
        if (r < 16)
            req.position = 8'($urandom_range(0, top));
        else if (r < 18)
            req.position = 8'($urandom_range(0, 255));
        else
            case ($urandom_range(0, 2))
                0:       req.position = 8'd0;
                1:       req.position = 8'd255;
                default: req.position = 8'((top == 0) ? 0 : top - 1);
            endcase
        if ($urandom_range(0, 4) == 0)
            case ($urandom_range(0, 3))
                0:       req.item_value = 32'sh8000_0000;
                1:       req.item_value = 32'sh7FFF_FFFF;
                2:       req.item_value = '0;
                default: req.item_value = '1;
            endcase
        else
            req.item_value = $urandom;
        return req;
    endfunction

    task automatic test_empty_guards;
        issue_op(OPC_REMOVE,   0,   32'h1111_1111);
        issue_op(OPC_POP_LAST, 0,   32'h0);
        issue_op(OPC_POP_AT,   5,   32'h0);
        issue_op(OPC_READ,     0,   32'h0);
        issue_op(OPC_WRITE,    0,   32'hDEAD_BEEF);
        issue_op(OPC_INSERT,   1,   32'h2222_2222);
        issue_op(OPC_UNUSED,   255, 32'hFFFF_FFFF);
    endtask

    task automatic test_list_edits;
        issue_op(OPC_INSERT,   0,   32'h8000_0000);
        issue_op(OPC_APPEND,   200, 32'h7FFF_FFFF);
        // Insert at the current length behaves as an append.
        issue_op(OPC_INSERT,   2,   32'hFFFF_FFFF);
        issue_op(OPC_INSERT,   1,   32'h1234_5678);
        issue_op(OPC_READ,     0,   32'h0);
        issue_op(OPC_READ,     1,   32'h0);
        issue_op(OPC_READ,     2,   32'h0);
        issue_op(OPC_READ,     3,   32'h0);
        issue_op(OPC_WRITE,    3,   32'h5555_AAAA);
        issue_op(OPC_READ,     3,   32'h0);
        issue_op(OPC_READ,     4,   32'h0);
        issue_op(OPC_POP_AT,   255, 32'h0);
        issue_op(OPC_REMOVE,   0,   32'h0);
        issue_op(OPC_POP_AT,   1,   32'h0);
        issue_op(OPC_POP_LAST, 0,   32'h0);
        issue_op(OPC_REMOVE,   0,   32'h0);
        issue_op(OPC_POP_LAST, 0,   32'h0);
    endtask

    task automatic test_fill_to_capacity;
        int guard;
        guard = 0;
        while (list_count < LIST_CAPACITY && guard < 3000) begin
            issue_request(make_request(MIX_GROW));
            guard++;
        end
        repeat (16)
            issue_request(make_request(MIX_GROW));
    endtask

    task automatic test_drain_to_empty;
        int guard;
        guard = 0;
        while (list_count > 0 && guard < 3000) begin
            issue_request(make_request(MIX_SHRINK));
            guard++;
        end
        repeat (16)
            issue_request(make_request(MIX_SHRINK));
    endtask

    task automatic test_random_mix;
        repeat (800)
            issue_request(make_request(MIX_EVEN));
    endtask

    task automatic test_steady_stream;
        idle_on = 1'b0;
        repeat (150)
            issue_request(make_request(MIX_EVEN));
    endtask

    task automatic wait_for_responses;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (LIST_CAPACITY + 8)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_guards();
        test_list_edits();
        test_fill_to_capacity();
        test_drain_to_empty();
        test_random_mix();
        test_steady_stream();
        wait_for_responses();

        if (mismatch_count == 0 && pending_rsp.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
